[sv/mbpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monotone bucket priority queue package
// Shared constants, operation codes, controller states and the command
// bundle for the pending-level bit array.
// ----------------------------------------------------------------------------
package mbpq_pkg;

    localparam int MBPQ_LEVELS    = 255;
    localparam int MBPQ_CAPACITY  = 16384;
    localparam int MBPQ_ITEM_BITS = 16;

    localparam int COST_W = 8;
    localparam int ITEM_W = 16;
    localparam int SCAN_G = 16;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_TAKE,
        ST_FETCH
    } t_state;

    typedef struct packed {
        logic clr_all;
        logic set;
        logic clr;
    } t_pend_cmd;

endpackage

[sv/monotone_bucket_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Monotone bucket priority queue
// Cost-level buckets of first-in first-out lists kept in synchronous RAM.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low.
// i_op selects clear, push or pop; i_cost and i_item carry the push data.
// Every transaction gives exactly one result: o_done is high for one cycle
// with o_popped_item, o_found and o_overflow valid in that cycle.
// The receiver cannot stall, so results are never held back or dropped.
// Clear, no-op and refused pushes finish at the accepting edge; the result
// shows in the next cycle and busy stays low.
// A stored push keeps busy high for one cycle: the tail pointer read.
// A pop searches the pending flags one group of 16 levels per cycle,
// starting at the lowest level. When an entry is taken, the search is
// followed by the head/tail read and then the payload/link read.
// Reset is synchronous and active low. It clears the pending flags, the
// pool counter and the lowest and highest levels; the RAMs are not swept.
// ----------------------------------------------------------------------------
module monotone_bucket_priority_queue import mbpq_pkg::*; #(
    parameter int LEVELS    = MBPQ_LEVELS,
    parameter int CAPACITY  = MBPQ_CAPACITY,
    parameter int ITEM_BITS = MBPQ_ITEM_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [1:0]        i_op,
    input  logic [COST_W-1:0] i_cost,
    input  logic [ITEM_W-1:0] i_item,
    output logic              busy,
    output logic              o_done,
    output logic [ITEM_W-1:0] o_popped_item,
    output logic              o_found,
    output logic              o_overflow
);

    localparam int LIW = $clog2(LEVELS);
    localparam int LW  = $clog2(LEVELS + 1);
    localparam int AW  = $clog2(CAPACITY);
    localparam int UW  = $clog2(CAPACITY + 1);
    localparam int NG  = (LEVELS + SCAN_G - 1) / SCAN_G;
    localparam int GW  = (NG > 1) ? $clog2(NG) : 1;

    t_state r_state, n_state;

    logic [LIW-1:0]       r_cost, n_cost;
    logic [ITEM_BITS-1:0] r_item, n_item;
    logic [GW-1:0]        r_grp, n_grp;
    logic [LIW-1:0]       r_level, n_level;
    logic                 r_last, n_last;
    logic [UW-1:0]        r_used, n_used;
    logic [LW-1:0]        r_lowest, n_lowest;
    logic [LIW-1:0]       r_highest, n_highest;
    logic                 r_done, n_done;
    logic [ITEM_W-1:0]    r_popped, n_popped;
    logic                 r_found, n_found;
    logic                 r_overflow, n_overflow;

    logic    w_accept;
    t_op     w_op;
    logic    w_lvl_ok;
    logic    w_full;
    logic    w_past_top;
    logic    w_grp_end;

    t_pend_cmd      w_pend_cmd;
    logic [LIW-1:0] w_pend_idx;
    logic           w_pend;
    logic           w_hit;
    logic [LIW-1:0] w_hit_idx;

    logic                 w_head_we, w_head_re;
    logic [LIW-1:0]       w_head_waddr, w_head_raddr;
    logic [AW-1:0]        w_head_wdata, w_head_rdata;
    logic                 w_tail_we, w_tail_re;
    logic [LIW-1:0]       w_tail_waddr, w_tail_raddr;
    logic [AW-1:0]        w_tail_wdata, w_tail_rdata;
    logic                 w_pay_we, w_pay_re;
    logic [AW-1:0]        w_pay_waddr, w_pay_raddr;
    logic [ITEM_BITS-1:0] w_pay_wdata, w_pay_rdata;
    logic                 w_link_we, w_link_re;
    logic [AW-1:0]        w_link_waddr, w_link_raddr;
    logic [AW-1:0]        w_link_wdata, w_link_rdata;

    assign busy       = (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_op       = t_op'(i_op);
    assign w_lvl_ok   = int'(i_cost) < LEVELS;
    assign w_full     = int'(r_used) >= CAPACITY;
    assign w_past_top = int'(r_lowest) > int'(r_highest);
    assign w_grp_end  = (int'(r_grp) * SCAN_G + SCAN_G - 1) >= int'(r_highest);

    mbpq_pending #(
        .LEVELS (LEVELS)
    ) u_pending (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_pend_cmd),
        .i_idx     (w_pend_idx),
        .o_pend    (w_pend),
        .i_grp     (r_grp),
        .i_low     (r_lowest),
        .o_hit     (w_hit),
        .o_hit_idx (w_hit_idx)
    );

    mbpq_ram #(.DEPTH(LEVELS), .WIDTH(AW)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (w_head_waddr),
        .i_wdata (w_head_wdata),
        .i_re    (w_head_re),
        .i_raddr (w_head_raddr),
        .o_rdata (w_head_rdata)
    );

    mbpq_ram #(.DEPTH(LEVELS), .WIDTH(AW)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (w_tail_we),
        .i_waddr (w_tail_waddr),
        .i_wdata (w_tail_wdata),
        .i_re    (w_tail_re),
        .i_raddr (w_tail_raddr),
        .o_rdata (w_tail_rdata)
    );

    mbpq_ram #(.DEPTH(CAPACITY), .WIDTH(ITEM_BITS)) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_pay_we),
        .i_waddr (w_pay_waddr),
        .i_wdata (w_pay_wdata),
        .i_re    (w_pay_re),
        .i_raddr (w_pay_raddr),
        .o_rdata (w_pay_rdata)
    );

    mbpq_ram #(.DEPTH(CAPACITY), .WIDTH(AW)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_re    (w_link_re),
        .i_raddr (w_link_raddr),
        .o_rdata (w_link_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_PUSH: begin
                            if (w_lvl_ok && !w_full) begin
                                n_state = ST_PUSH;
                            end
                        end
                        OP_POP:  n_state = ST_SCAN;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH: n_state = ST_IDLE;
            ST_SCAN: begin
                if (w_past_top) begin
                    n_state = ST_IDLE;
                end else if (w_hit) begin
                    n_state = ST_TAKE;
                end else if (w_grp_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TAKE:  n_state = ST_FETCH;
            ST_FETCH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cost     = r_cost;
        n_item     = r_item;
        n_grp      = r_grp;
        n_level    = r_level;
        n_last     = r_last;
        n_used     = r_used;
        n_lowest   = r_lowest;
        n_highest  = r_highest;
        n_done     = 1'b0;
        n_popped   = '0;
        n_found    = 1'b0;
        n_overflow = 1'b0;

        w_pend_cmd = '0;
        w_pend_idx = (r_state == ST_PUSH) ? r_cost : r_level;

        w_head_we    = 1'b0;
        w_head_waddr = r_level;
        w_head_wdata = w_link_rdata;
        w_head_re    = 1'b0;
        w_head_raddr = w_hit_idx;
        w_tail_we    = 1'b0;
        w_tail_waddr = r_cost;
        w_tail_wdata = AW'(r_used);
        w_tail_re    = 1'b0;
        w_tail_raddr = w_hit_idx;
        w_pay_we     = 1'b0;
        w_pay_waddr  = AW'(r_used);
        w_pay_wdata  = r_item;
        w_pay_re     = 1'b0;
        w_pay_raddr  = w_head_rdata;
        w_link_we    = 1'b0;
        w_link_waddr = w_tail_rdata;
        w_link_wdata = AW'(r_used);
        w_link_re    = 1'b0;
        w_link_raddr = w_head_rdata;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cost       = LIW'(i_cost);
                    n_item       = ITEM_BITS'(i_item);
                    w_tail_re    = 1'b1;
                    w_tail_raddr = LIW'(i_cost);
                    case (w_op)
                        OP_CLEAR: begin
                            w_pend_cmd.clr_all = 1'b1;
                            n_used    = '0;
                            n_lowest  = '0;
                            n_highest = '0;
                            n_done    = 1'b1;
                        end
                        OP_PUSH: begin
                            if (!w_lvl_ok) begin
                                n_done = 1'b1;
                            end else if (w_full) begin
                                n_done     = 1'b1;
                                n_overflow = 1'b1;
                            end
                        end
                        OP_POP: begin
                            n_grp = GW'(r_lowest / SCAN_G);
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_PUSH: begin
                w_pay_we       = 1'b1;
                w_tail_we      = 1'b1;
                w_pend_cmd.set = 1'b1;
                if (w_pend) begin
                    w_link_we = 1'b1;
                end else begin
                    w_head_we    = 1'b1;
                    w_head_waddr = r_cost;
                    w_head_wdata = AW'(r_used);
                end
                n_used = r_used + UW'(1);
                if (r_cost > r_highest) begin
                    n_highest = r_cost;
                end
                n_done = 1'b1;
            end
            ST_SCAN: begin
                if (w_past_top) begin
                    n_done = 1'b1;
                end else if (w_hit) begin
                    w_head_re = 1'b1;
                    w_tail_re = 1'b1;
                    n_level   = w_hit_idx;
                    n_lowest  = LW'(w_hit_idx);
                end else if (w_grp_end) begin
                    n_lowest = LW'(int'(r_highest) + 1);
                    n_done   = 1'b1;
                end else begin
                    n_grp = r_grp + GW'(1);
                end
            end
            ST_TAKE: begin
                w_pay_re  = 1'b1;
                w_link_re = 1'b1;
                n_last    = (w_head_rdata == w_tail_rdata);
                if (w_head_rdata == w_tail_rdata) begin
                    w_pend_cmd.clr = 1'b1;
                end
            end
            ST_FETCH: begin
                if (!r_last) begin
                    w_head_we = 1'b1;
                end
                n_done   = 1'b1;
                n_found  = 1'b1;
                n_popped = ITEM_W'(w_pay_rdata);
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_lowest  <= '0;
            r_highest <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_lowest  <= n_lowest;
            r_highest <= n_highest;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cost     <= n_cost;
        r_item     <= n_item;
        r_grp      <= n_grp;
        r_level    <= n_level;
        r_last     <= n_last;
        r_popped   <= n_popped;
        r_found    <= n_found;
        r_overflow <= n_overflow;
    end

    assign o_done        = r_done;
    assign o_popped_item = r_popped;
    assign o_found       = r_found;
    assign o_overflow    = r_overflow;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_used) <= CAPACITY)
        else $error("Pool counter exceeds capacity.");

    a_lowest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_lowest) <= int'(r_highest) + 1)
        else $error("Lowest level ran more than one past the highest level.");

    a_fetch_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |=> (o_done && o_found && !o_overflow))
        else $error("Payload fetch did not produce a found result.");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> !w_full)
        else $error("Push stored into a full pool.");

endmodule

[sv/mbpq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mbpq_ram import mbpq_pkg::*; #(
    parameter int DEPTH = MBPQ_LEVELS,
    parameter int WIDTH = ITEM_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mbpq_pending.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pending-level bit array
// One flag per cost level, cleared at reset, with a priority search over
// one group of levels per cycle at or above the lowest level.
// ----------------------------------------------------------------------------
module mbpq_pending import mbpq_pkg::*; #(
    parameter int LEVELS = MBPQ_LEVELS,
    localparam int LIW   = $clog2(LEVELS),
    localparam int LW    = $clog2(LEVELS + 1),
    localparam int NG    = (LEVELS + SCAN_G - 1) / SCAN_G,
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_pend_cmd      i_cmd,
    input  logic [LIW-1:0] i_idx,
    output logic           o_pend,
    input  logic [GW-1:0]  i_grp,
    input  logic [LW-1:0]  i_low,
    output logic           o_hit,
    output logic [LIW-1:0] o_hit_idx
);

    logic [LEVELS-1:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_pend <= '0;
        end else if (i_cmd.set) begin
            r_pend[i_idx] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_pend[i_idx] <= 1'b0;
        end
    end

    assign o_pend = r_pend[i_idx];

    // The lowest qualifying level in the group wins.
    always_comb begin
        int lvl;
        o_hit     = 1'b0;
        o_hit_idx = '0;
        for (int j = SCAN_G - 1; j >= 0; j--) begin
            lvl = int'(i_grp) * SCAN_G + j;
            if (lvl < LEVELS && lvl >= int'(i_low) && r_pend[LIW'(lvl)]) begin
                o_hit     = 1'b1;
                o_hit_idx = LIW'(lvl);
            end
        end
    end

endmodule
